[hw/rtl/sidt_pkg.sv]
// Shared types and codes for the sorted id offset table.
// Used by sidt_alu and sorted_id_offset_table under hw/rtl; depends on nothing else.
package sidt_pkg;

    localparam int KEY_W = 64;
    localparam int POS_W = 11;
    localparam int IDX_W = 10;

    // operation codes
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOT_INC = 3'd1;
    localparam logic [2:0] ST_OFF_BIG = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_RANGE   = 3'd4;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [KEY_W-1:0] key;
        logic             start_load;
        logic [IDX_W-1:0] entry_index;
    } t_in_item;

    typedef struct packed {
        logic [2:0]       status;
        logic [POS_W-1:0] position;
        logic [KEY_W-1:0] id_out;
    } t_out_item;

endpackage

[hw/rtl/sidt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module sidt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/sidt_alu.sv]
// Shared 64-bit add/subtract unit for all key/offset compares and sums.
// Depends on sidt_pkg for the key width.
module sidt_alu (
    input  logic [sidt_pkg::KEY_W-1:0] i_a,
    input  logic [sidt_pkg::KEY_W-1:0] i_b,
    input  logic                       i_sub,
    output logic [sidt_pkg::KEY_W-1:0] o_sum,
    output logic                       o_carry
);

    logic [sidt_pkg::KEY_W-1:0] b_op;
    logic [sidt_pkg::KEY_W:0]   full_sum;

    // subtract as a + ~b + 1; carry high means no borrow
    assign b_op     = i_sub ? ~i_b : i_b;
    assign full_sum = {1'b0, i_a} + {1'b0, b_op}
                      + {{sidt_pkg::KEY_W{1'b0}}, i_sub};
    assign o_sum    = full_sum[sidt_pkg::KEY_W-1:0];
    assign o_carry  = full_sum[sidt_pkg::KEY_W];

endmodule

[hw/rtl/sorted_id_offset_table.sv]
// A query runs a binary search of up to ceil(log2(n+1)) steps over the n stored offsets,
// each step a read of the offset memory and a compare in the shared adder.
// One item at a time: the next input is taken the cycle after its result is registered,
// set by the single shared adder and the one read port of the offset memory.
// Reset (synchronous, active low) empties the table; offset memory is not cleared.
module sorted_id_offset_table #(
    parameter int DEPTH       = 1024,
    parameter int OFFSET_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  sidt_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output sidt_pkg::t_out_item  o_out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = sidt_pkg::KEY_W;
    localparam int PW = sidt_pkg::POS_W;

    typedef enum logic [9:0] {
        S_IDLE      = 10'b0000000001,
        S_APP_START = 10'b0000000010,
        S_APP_CHK   = 10'b0000000100,
        S_APP_OFF   = 10'b0000001000,
        S_Q_SUB     = 10'b0000010000,
        S_Q_RD      = 10'b0000100000,
        S_Q_CMP     = 10'b0001000000,
        S_RD_ADDR   = 10'b0010000000,
        S_RD_ADD    = 10'b0100000000,
        S_DONE      = 10'b1000000000
    } t_state;

    t_state              r_state, n_state;
    logic [1:0]          r_op, n_op;
    logic [KW-1:0]       r_key, n_key;
    logic [sidt_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [KW-1:0]       r_base, n_base;
    logic [KW-1:0]       r_last, n_last;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_lo, n_lo;
    logic [CW-1:0]       r_hi, n_hi;
    logic [CW-1:0]       r_mid, n_mid;
    logic [OFFSET_BITS-1:0] r_rel, n_rel;
    sidt_pkg::t_out_item r_res, n_res;
    sidt_pkg::t_out_item r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic [KW-1:0]          alu_a, alu_b, alu_sum;
    logic                   alu_sub, alu_carry;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [OFFSET_BITS-1:0] ram_wdata, ram_rdata;
    logic [CW:0]            mid_sum;
    logic [CW-1:0]          mid;
    logic                   in_xfer;
    logic                   off_big;

    sidt_alu u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_sub   (alu_sub),
        .o_sum   (alu_sum),
        .o_carry (alu_carry)
    );

    sidt_ram #(
        .WIDTH (OFFSET_BITS),
        .DEPTH (DEPTH)
    ) u_offsets (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // midpoint of the live search window
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[CW:1];
    assign off_big = |alu_sum[KW-1:OFFSET_BITS];

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key       = r_key;
        n_idx       = r_idx;
        n_base      = r_base;
        n_last      = r_last;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_rel       = r_rel;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        alu_a       = r_key;
        alu_b       = r_last;
        alu_sub     = 1'b1;
        ram_we      = 1'b0;
        ram_waddr   = r_count[AW-1:0];
        ram_wdata   = alu_sum[OFFSET_BITS-1:0];
        ram_raddr   = r_mid[AW-1:0];

        // drop the held result once taken
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op  = i_in_data.opcode;
                    n_key = i_in_data.key;
                    n_idx = i_in_data.entry_index;
                    n_res = '{status: sidt_pkg::ST_OK, position: '0, id_out: '0};
                    case (i_in_data.opcode)
                        sidt_pkg::OP_APPEND: begin
                            n_state = (i_in_data.start_load || (r_count == '0))
                                      ? S_APP_START : S_APP_CHK;
                        end
                        sidt_pkg::OP_QUERY: begin
                            n_state = (r_count == '0) ? S_DONE : S_Q_SUB;
                        end
                        sidt_pkg::OP_READ: begin
                            if (32'(i_in_data.entry_index) >= 32'(r_count)) begin
                                n_res.status = sidt_pkg::ST_RANGE;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_RD_ADDR;
                            end
                        end
                        default: begin
                            n_base  = '0;
                            n_last  = '0;
                            n_count = '0;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_APP_START: begin
                ram_we          = 1'b1;
                ram_waddr       = '0;
                ram_wdata       = '0;
                n_base          = r_key;
                n_last          = r_key;
                n_count         = CW'(1);
                n_res.position  = PW'(1);
                n_state         = S_DONE;
            end
            S_APP_CHK: begin
                // key must exceed the last id
                alu_a = r_key;
                alu_b = r_last;
                if (!alu_carry || (alu_sum == '0)) begin
                    n_res.status = sidt_pkg::ST_NOT_INC;
                    n_base       = '0;
                    n_last       = '0;
                    n_count      = '0;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_APP_OFF;
                end
            end
            S_APP_OFF: begin
                alu_a = r_key;
                alu_b = r_base;
                if (off_big || (r_count >= CW'(DEPTH))) begin
                    n_res.status = off_big ? sidt_pkg::ST_OFF_BIG : sidt_pkg::ST_FULL;
                    n_base       = '0;
                    n_last       = '0;
                    n_count      = '0;
                end else begin
                    ram_we         = 1'b1;
                    n_count        = r_count + CW'(1);
                    n_last         = r_key;
                    n_res.position = PW'(r_count + CW'(1));
                end
                n_state = S_DONE;
            end
            S_Q_SUB: begin
                alu_a = r_key;
                alu_b = r_base;
                if (!alu_carry || (alu_sum == '0)) begin
                    n_state = S_DONE;
                end else if (off_big) begin
                    n_res.position = PW'(r_count);
                    n_state        = S_DONE;
                end else begin
                    n_rel   = alu_sum[OFFSET_BITS-1:0];
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_state = S_Q_RD;
                end
            end
            S_Q_RD: begin
                if (r_lo < r_hi) begin
                    ram_raddr = mid[AW-1:0];
                    n_mid     = mid;
                    n_state   = S_Q_CMP;
                end else begin
                    n_res.position = PW'(r_lo);
                    n_state        = S_DONE;
                end
            end
            S_Q_CMP: begin
                // narrow the window on offset < rel
                alu_a = KW'(ram_rdata);
                alu_b = KW'(r_rel);
                if (!alu_carry) begin
                    n_lo = r_mid + CW'(1);
                end else begin
                    n_hi = r_mid;
                end
                n_state = S_Q_RD;
            end
            S_RD_ADDR: begin
                ram_raddr = AW'(r_idx);
                n_state   = S_RD_ADD;
            end
            S_RD_ADD: begin
                alu_a        = r_base;
                alu_b        = KW'(ram_rdata);
                alu_sub      = 1'b0;
                n_res.id_out = alu_sum;
                n_state      = S_DONE;
            end
            S_DONE: begin
                // hand over once the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and table state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_base      <= '0;
            r_last      <= '0;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_base      <= n_base;
            r_last      <= n_last;
            r_count     <= n_count;
        end
    end

    // payload and search registers
    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_key <= n_key;
        r_idx <= n_idx;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        r_rel <= n_rel;
        r_res <= n_res;
        r_out <= n_out;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_window_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_Q_RD) |-> (r_lo <= r_hi))
        else $error("search window inverted");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_in_data.opcode == sidt_pkg::OP_CLEAR)) |=> (r_count == '0))
        else $error("clear left entries");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && (r_state == S_APP_OFF)) |-> (r_count < CW'(DEPTH)))
        else $error("offset write with table full");

    a_op_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_Q_CMP) |-> (r_op == sidt_pkg::OP_QUERY))
        else $error("search step outside a query");
`endif

endmodule

[bench/sorted_id_offset_table_tb.sv]
// Self-checking bench for sorted_id_offset_table: directed and random appends, lower-bound
// queries, reads and clears against a scoreboard with its own base-plus-offset table.
// Depends on sidt_pkg and the sorted_id_offset_table RTL only.
`timescale 1ns / 1ps

module sorted_id_offset_table_tb;

    localparam int          DEPTH        = 1024;
    localparam int          OFFSET_BITS  = 32;
    localparam int          POS_W        = sidt_pkg::POS_W;
    localparam logic [63:0] OFFSET_LIMIT = (64'd1 << OFFSET_BITS) - 64'd1;
    localparam logic [63:0] KEY_MAX      = '1;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    sidt_pkg::t_in_item  i_in_data;
    logic                o_out_valid;
    logic                i_out_ready;
    sidt_pkg::t_out_item o_out_data;

    int sender_idle_pct;
    int recv_idle_pct;
    int items_sent;
    bit hold_req;
    int hold_left;

    // Mirror of the id table; predicts each result and queues it for comparison
    class id_table_scoreboard;
        logic [63:0]            base_id;
        logic [63:0]            last_id;
        int unsigned            entry_count;
        logic [OFFSET_BITS-1:0] offsets [DEPTH];
        sidt_pkg::t_out_item    pending_results [$];
        int                     errors;

        function new();
            base_id     = '0;
            last_id     = '0;
            entry_count = 0;
            errors      = 0;
            foreach (offsets[i]) offsets[i] = '0;
        endfunction

        function void empty_ids();
            base_id     = '0;
            last_id     = '0;
            entry_count = 0;
        endfunction

        // Apply one request to the mirror and return the result it produces
        function sidt_pkg::t_out_item apply_op(sidt_pkg::t_in_item req);
            sidt_pkg::t_out_item res;
            logic [63:0]         rel;
            int unsigned         lo;
            int unsigned         hi;
            int unsigned         mid;
            res = '0;
            case (req.opcode)
                sidt_pkg::OP_APPEND: begin
                    if (req.start_load || entry_count == 0) begin
                        base_id     = req.key;
                        last_id     = req.key;
                        offsets[0]  = '0;
                        entry_count = 1;
                        res.position = POS_W'(1);
                    end else begin
                        rel = req.key - base_id;
                        if (req.key <= last_id)
                            res.status = sidt_pkg::ST_NOT_INC;
                        else if (rel > OFFSET_LIMIT)
                            res.status = sidt_pkg::ST_OFF_BIG;
                        else if (entry_count >= DEPTH)
                            res.status = sidt_pkg::ST_FULL;
                        if (res.status != sidt_pkg::ST_OK) begin
                            empty_ids();
                        end else begin
                            offsets[entry_count] = rel[OFFSET_BITS-1:0];
                            entry_count++;
                            last_id      = req.key;
                            res.position = POS_W'(entry_count);
                        end
                    end
                end
                sidt_pkg::OP_QUERY: begin
                    if (entry_count != 0 && req.key > base_id) begin
                        rel = req.key - base_id;
                        if (rel > OFFSET_LIMIT) begin
                            res.position = POS_W'(entry_count);
                        end else begin
                            lo = 0;
                            hi = entry_count;
                            while (lo < hi) begin
                                mid = lo + (hi - lo) / 2;
                                if (64'(offsets[mid]) < rel)
                                    lo = mid + 1;
                                else
                                    hi = mid;
                            end
                            res.position = POS_W'(lo);
                        end
                    end
                end
                sidt_pkg::OP_READ: begin
                    if (req.entry_index >= entry_count)
                        res.status = sidt_pkg::ST_RANGE;
                    else
                        res.id_out = base_id + 64'(offsets[req.entry_index]);
                end
                default: empty_ids();
            endcase
            return res;
        endfunction

        function void note_request(sidt_pkg::t_in_item req);
            pending_results = {pending_results, apply_op(req)};
        endfunction

        function void check_response(sidt_pkg::t_out_item got);
            sidt_pkg::t_out_item want;
            if (pending_results.size() == 0) begin
                $error("result with none outstanding: status %0d position %0d id_out %h",
                       got.status, got.position, got.id_out);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.position !== want.position) begin
                $error("position: expected %0d, got %0d", want.position, got.position);
                errors++;
            end
            if (got.id_out !== want.id_out) begin
                $error("id_out: expected %h, got %h", want.id_out, got.id_out);
                errors++;
            end
        endfunction
    endclass

    id_table_scoreboard sb;

    sorted_id_offset_table #(
        .DEPTH       (DEPTH),
        .OFFSET_BITS (OFFSET_BITS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Give up after a generous bound
    initial begin
        #10_000_000;
        $display("sorted_id_offset_table_tb failed");
        $finish;
    end

    // Drive result ready: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check every result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_response(o_out_data);
    end

    function automatic logic [63:0] random_key();
        return {$urandom(), $urandom()};
    endfunction

    // Offer one request, idling first at random; valid stays high after the transfer
    task automatic send_op(logic [1:0] op, logic [63:0] key, logic start, logic [9:0] idx);
        sidt_pkg::t_in_item req;
        req.opcode      = op;
        req.key         = key;
        req.start_load  = start;
        req.entry_index = idx;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_request(req);
        items_sent++;
    endtask

    // Drop valid and hold until every outstanding result has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [63:0] pick_base();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 64'd0;
        if (r == 1) return KEY_MAX - $urandom_range(0, 1 << 20);
        if (r == 2) return KEY_MAX - OFFSET_LIMIT - $urandom_range(0, 100);
        return random_key();
    endfunction

    // Mostly well-formed loads followed by lookups, with some broken appends and noise
    task automatic run_random(int upto);
        logic [63:0] ids [$];
        logic [63:0] base;
        logic [63:0] last;
        logic [63:0] key;
        int          r;
        int          k;
        int          m;
        bit          broken;
        while (items_sent < upto) begin
            if ($urandom_range(99) < 75) begin
                base = pick_base();
                if ($urandom_range(9) == 0) begin
                    send_op(sidt_pkg::OP_CLEAR, random_key(), 1'($urandom_range(1)),
                            10'($urandom_range(1023)));
                    send_op(sidt_pkg::OP_APPEND, base, 1'b0, 10'($urandom_range(1023)));
                end else begin
                    send_op(sidt_pkg::OP_APPEND, base, 1'b1, 10'($urandom_range(1023)));
                end
                ids.delete();
                ids = {ids, base};
                last = base;
                k = $urandom_range(0, 40);
                for (int i = 0; i < k; i++) begin
                    r = $urandom_range(99);
                    broken = 1'b0;
                    if (r < 55) begin
                        key = last + $urandom_range(1, 16);
                    end else if (r < 85) begin
                        key = last + $urandom_range(1, 1 << 20);
                    end else if (r < 94) begin
                        key = base + OFFSET_LIMIT - $urandom_range(0, 3);
                    end else if (r < 97) begin
                        key    = last - $urandom_range(0, 2);
                        broken = 1'b1;
                    end else begin
                        key    = base + OFFSET_LIMIT + 1 + $urandom_range(0, 5);
                        broken = 1'b1;
                    end
                    send_op(sidt_pkg::OP_APPEND, key, 1'b0, 10'($urandom_range(1023)));
                    if (broken) break;
                    ids = {ids, key};
                    last = key;
                end
                m = $urandom_range(1, 12);
                for (int i = 0; i < m; i++) begin
                    if ($urandom_range(1)) begin
                        case ($urandom_range(7))
                            0: key = base - 1;
                            1: key = base;
                            2: key = ids[$urandom_range(ids.size() - 1)];
                            3: key = ids[$urandom_range(ids.size() - 1)] + 1;
                            4: key = last + 1;
                            5: key = base + OFFSET_LIMIT;
                            6: key = base + OFFSET_LIMIT + 1;
                            default: key = random_key();
                        endcase
                        send_op(sidt_pkg::OP_QUERY, key, 1'($urandom_range(1)),
                                10'($urandom_range(1023)));
                    end else if ($urandom_range(4) != 0) begin
                        send_op(sidt_pkg::OP_READ, random_key(), 1'($urandom_range(1)),
                                10'($urandom_range(0, ids.size() + 1)));
                    end else begin
                        send_op(sidt_pkg::OP_READ, random_key(), 1'($urandom_range(1)),
                                10'($urandom_range(1023)));
                    end
                end
            end else begin
                send_op(2'($urandom_range(3)), random_key(), 1'($urandom_range(1)),
                        10'($urandom_range(1023)));
            end
        end
    endtask

    // Load every entry, probe the full table, then overflow it
    task automatic fill_to_capacity();
        logic [63:0] base;
        logic [63:0] last;
        base = random_key() >> 1;
        last = base;
        send_op(sidt_pkg::OP_APPEND, base, 1'b1, '0);
        for (int i = 1; i < DEPTH; i++) begin
            last = last + $urandom_range(1, 4_000_000);
            send_op(sidt_pkg::OP_APPEND, last, 1'b0, 10'($urandom_range(1023)));
        end
        for (int i = 0; i < 8; i++)
            send_op(sidt_pkg::OP_QUERY, base + $urandom_range(0, 32'(last - base)), 1'b0, '0);
        send_op(sidt_pkg::OP_QUERY, last, 1'b0, '0);
        send_op(sidt_pkg::OP_QUERY, last + 1, 1'b0, '0);
        send_op(sidt_pkg::OP_READ, '0, 1'b0, 10'(DEPTH - 1));
        send_op(sidt_pkg::OP_READ, '0, 1'b0, 10'($urandom_range(1023)));
        send_op(sidt_pkg::OP_APPEND, last + 1, 1'b0, '0);
        send_op(sidt_pkg::OP_READ, '0, 1'b0, '0);
    endtask

    initial begin
        sb = new();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_ready <= 1'b0;
        sender_idle_pct = 17;
        recv_idle_pct   = 85;
        items_sent      = 0;
        hold_req        = 1'b0;
        hold_left       = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table: query, out-of-range reads, clear
        send_op(sidt_pkg::OP_QUERY, 64'd5, 1'b0, '0);
        send_op(sidt_pkg::OP_READ, '0, 1'b0, '0);
        send_op(sidt_pkg::OP_READ, '0, 1'b0, 10'd1023);
        send_op(sidt_pkg::OP_CLEAR, '0, 1'b0, '0);
        // Append to an empty table without start behaves as a start
        send_op(sidt_pkg::OP_APPEND, 64'd100, 1'b0, '0);
        send_op(sidt_pkg::OP_APPEND, 64'd100, 1'b0, '0);
        // Base of zero, offset exactly at the limit, then one past it
        send_op(sidt_pkg::OP_APPEND, 64'd0, 1'b1, '0);
        send_op(sidt_pkg::OP_APPEND, OFFSET_LIMIT, 1'b0, '0);
        send_op(sidt_pkg::OP_QUERY, 64'd0, 1'b0, '0);
        send_op(sidt_pkg::OP_QUERY, 64'd1, 1'b0, '0);
        send_op(sidt_pkg::OP_QUERY, OFFSET_LIMIT + 1, 1'b0, '0);
        send_op(sidt_pkg::OP_QUERY, KEY_MAX, 1'b0, '0);
        send_op(sidt_pkg::OP_READ, '0, 1'b0, 10'd1);
        send_op(sidt_pkg::OP_READ, '0, 1'b0, 10'd2);
        send_op(sidt_pkg::OP_APPEND, OFFSET_LIMIT + 1, 1'b0, '0);
        send_op(sidt_pkg::OP_READ, '0, 1'b0, '0);
        // Top of the key range
        send_op(sidt_pkg::OP_APPEND, KEY_MAX - 5, 1'b1, '0);
        send_op(sidt_pkg::OP_APPEND, KEY_MAX, 1'b0, '0);
        send_op(sidt_pkg::OP_QUERY, KEY_MAX, 1'b0, '0);
        send_op(sidt_pkg::OP_READ, '0, 1'b1, 10'd1);
        send_op(sidt_pkg::OP_APPEND, KEY_MAX, 1'b1, '0);
        send_op(sidt_pkg::OP_QUERY, KEY_MAX, 1'b0, '0);
        send_op(sidt_pkg::OP_CLEAR, KEY_MAX, 1'b1, 10'd1023);
        send_op(sidt_pkg::OP_QUERY, 64'd3, 1'b0, '0);

        run_random(30);
        wait_drained();

        // Swap the idling; start with a long result stall so the input backs up
        sender_idle_pct = 85;
        recv_idle_pct   = 17;
        hold_req        = 1'b1;
        run_random(70);
        wait_drained();

        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        fill_to_capacity();
        wait_drained();
        run_random(items_sent + 10);
        i_in_valid <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0)
            $display("sorted_id_offset_table_tb passed");
        else
            $display("sorted_id_offset_table_tb failed");
        $finish;
    end

endmodule
